@@ hdl/dbmr_pkg.sv @@
// ----------------------------------------------------------------------------
// dbmr_pkg: shared types and codes for the doorbell mailbox registers
// Request kinds, register indexes, status bit positions and the beat structs
// that pass between the pipeline stages.
// ----------------------------------------------------------------------------
package dbmr_pkg;

   localparam int DataWidth = 32;
   localparam int StatusWidth = 4;

   localparam int StReadyBit = 0;
   localparam int StGuestReadyBit = 1;
   localparam int StInPendingBit = 2;

   localparam logic [StatusWidth-1:0] StatusResetValue = 4'h1;

   typedef enum logic [1:0] {
      KIND_GUEST_READ   = 2'd0,
      KIND_GUEST_WRITE  = 2'd1,
      KIND_HOST_PUBLISH = 2'd2,
      KIND_HOST_CONSUME = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      REG_STATUS       = 4'd0,
      REG_OUT_BASE     = 4'd1,
      REG_OUT_LENGTH   = 4'd2,
      REG_OUT_WRITE    = 4'd3,
      REG_OUT_READ     = 4'd4,
      REG_OUT_DOORBELL = 4'd5,
      REG_IN_BASE      = 4'd6,
      REG_IN_LENGTH    = 4'd7,
      REG_IN_WRITE     = 4'd8,
      REG_IN_READ      = 4'd9,
      REG_IN_DOORBELL  = 4'd10,
      REG_IRQ_ENABLE   = 4'd11
   } reg_index_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [3:0]           reg_index;
      logic [DataWidth-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [DataWidth-1:0] read_data;
      logic                 irq_level;
      logic                 host_notify;
      logic                 bad_access;
   } rsp_item_type;

endpackage

@@ hdl/doorbell_mailbox_registers.sv @@
// ----------------------------------------------------------------------------
// doorbell_mailbox_registers: two-way mailbox register block with doorbells
// Guest register accesses and host index events read or update the mailbox state
// and give one response beat each, carrying read data and interrupt status.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                                   Beat
//   req      in         req_type, req_reg_index, req_value       one request
//   rsp      out        rsp_read_data, rsp_irq_level,            one response
//                       rsp_host_notify, rsp_bad_access
//   csr      in         csr_notify_enabled                       register write
//
// Each request is captured in an input register and decoded by the register
// file once the output register is free to take its response, which is then
// held there; one request is taken in every cycle while rsp_ready stays high.
// Synchronous reset restores the control flags and the mailbox registers.
// A stalled response holds the output register and the input register fills
// behind it; req_ready then drops until rsp_ready returns.
module doorbell_mailbox_registers
   import dbmr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [3:0]           req_reg_index,
   input  logic [DataWidth-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DataWidth-1:0] rsp_read_data,
   output logic                 rsp_irq_level,
   output logic                 rsp_host_notify,
   output logic                 rsp_bad_access,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_notify_enabled
);

   req_item_type in_item, stage_item;
   rsp_item_type step_result;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         notify_ff, notify_in;
   logic         stage_valid, step;

   assign in_item.kind = req_kind_type'(req_type);
   assign in_item.reg_index = req_reg_index;
   assign in_item.value = req_value;

   assign step = stage_valid && (!rsp_valid_ff || rsp_ready);

   dbmr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (in_item),
      .out_valid (stage_valid),
      .out_take  (step),
      .out_item  (stage_item)
   );

   dbmr_regfile u_regfile (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .notify_enabled (notify_ff),
      .item           (stage_item),
      .result         (step_result)
   );

   assign csr_ready = 1'b1;
   assign notify_in = (csr_valid && csr_ready) ? csr_notify_enabled : notify_ff;

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   assign rsp_in = step ? step_result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         notify_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         notify_ff <= notify_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq_level = rsp_ff.irq_level;
   assign rsp_host_notify = rsp_ff.host_notify;
   assign rsp_bad_access = rsp_ff.bad_access;

endmodule

@@ hdl/dbmr_in_stage.sv @@
// ----------------------------------------------------------------------------
// dbmr_in_stage: request input register
// Captures one request beat and holds it until the register stage takes it.
// ----------------------------------------------------------------------------
module dbmr_in_stage
   import dbmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   assign in_ready = !valid_ff || out_take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_take);
   assign item_in = (in_valid && in_ready) ? in_item : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

@@ hdl/dbmr_regfile.sv @@
// ----------------------------------------------------------------------------
// dbmr_regfile: mailbox register file and side-effect logic
// Holds the guest-visible registers, status and interrupt line, decodes one
// request and forms its result.
// ----------------------------------------------------------------------------
module dbmr_regfile
   import dbmr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         notify_enabled,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [StatusWidth-1:0] status_ff, status_in;
   logic [DataWidth-1:0]   out_base_ff, out_base_in;
   logic [DataWidth-1:0]   out_length_ff, out_length_in;
   logic [DataWidth-1:0]   out_producer_ff, out_producer_in;
   logic [DataWidth-1:0]   out_consumer_ff, out_consumer_in;
   logic                   out_doorbell_ff, out_doorbell_in;
   logic [DataWidth-1:0]   in_base_ff, in_base_in;
   logic [DataWidth-1:0]   in_length_ff, in_length_in;
   logic [DataWidth-1:0]   in_producer_ff, in_producer_in;
   logic [DataWidth-1:0]   in_consumer_ff, in_consumer_in;
   logic                   in_doorbell_ff, in_doorbell_in;
   logic                   irq_allowed_ff, irq_allowed_in;
   logic                   irq_line_ff, irq_line_in;
   logic [DataWidth-1:0]   read_data;
   logic                   notify, bad;

   always_comb begin
      status_in = status_ff;
      out_base_in = out_base_ff;
      out_length_in = out_length_ff;
      out_producer_in = out_producer_ff;
      out_consumer_in = out_consumer_ff;
      out_doorbell_in = out_doorbell_ff;
      in_base_in = in_base_ff;
      in_length_in = in_length_ff;
      in_producer_in = in_producer_ff;
      in_consumer_in = in_consumer_ff;
      in_doorbell_in = in_doorbell_ff;
      irq_allowed_in = irq_allowed_ff;
      irq_line_in = irq_line_ff;
      read_data = '0;
      notify = 1'b0;
      bad = 1'b0;
      case (item.kind)
         KIND_GUEST_READ: begin
            case (item.reg_index)
               REG_STATUS:       read_data = DataWidth'(status_ff);
               REG_OUT_BASE:     read_data = out_base_ff;
               REG_OUT_LENGTH:   read_data = out_length_ff;
               REG_OUT_WRITE:    read_data = out_producer_ff;
               REG_OUT_READ:     read_data = out_consumer_ff;
               REG_OUT_DOORBELL: read_data = DataWidth'(out_doorbell_ff);
               REG_IN_BASE:      read_data = in_base_ff;
               REG_IN_LENGTH:    read_data = in_length_ff;
               REG_IN_WRITE:     read_data = in_producer_ff;
               REG_IN_READ:      read_data = in_consumer_ff;
               REG_IN_DOORBELL:  read_data = DataWidth'(in_doorbell_ff);
               REG_IRQ_ENABLE:   read_data = DataWidth'(irq_allowed_ff);
               default:          bad = 1'b1;
            endcase
         end
         KIND_GUEST_WRITE: begin
            case (item.reg_index)
               REG_STATUS:     status_in = item.value[StatusWidth-1:0];
               REG_OUT_BASE: begin
                  out_base_in = item.value;
                  status_in[StGuestReadyBit] = 1'b1;
               end
               REG_OUT_LENGTH: out_length_in = item.value;
               REG_OUT_WRITE, REG_OUT_READ: out_consumer_in = item.value;
               REG_OUT_DOORBELL: begin
                  if (item.value == '0) begin
                     out_doorbell_in = 1'b0;
                     irq_line_in = 1'b0;
                  end
               end
               REG_IN_BASE:    in_base_in = item.value;
               REG_IN_LENGTH:  in_length_in = item.value;
               REG_IN_WRITE:   in_producer_in = item.value;
               REG_IN_READ:    in_consumer_in = item.value;
               REG_IN_DOORBELL: begin
                  if (item.value == DataWidth'(1)) begin
                     in_doorbell_in = 1'b1;
                     status_in[StInPendingBit] = 1'b1;
                     notify = notify_enabled;
                  end else begin
                     in_doorbell_in = 1'b0;
                     status_in[StInPendingBit] = 1'b0;
                  end
               end
               REG_IRQ_ENABLE: begin
                  irq_allowed_in = (item.value != '0);
                  if (item.value == '0) begin
                     irq_line_in = 1'b0;
                  end
               end
               default: bad = 1'b1;
            endcase
         end
         KIND_HOST_PUBLISH: begin
            out_producer_in = item.value;
            out_doorbell_in = 1'b1;
            if (irq_allowed_ff) begin
               irq_line_in = 1'b1;
            end
         end
         KIND_HOST_CONSUME: begin
            in_consumer_in = item.value;
         end
         default: begin
            in_consumer_in = item.value;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= StatusResetValue;
         out_base_ff <= '0;
         out_length_ff <= '0;
         out_producer_ff <= '0;
         out_consumer_ff <= '0;
         out_doorbell_ff <= 1'b0;
         in_base_ff <= '0;
         in_length_ff <= '0;
         in_producer_ff <= '0;
         in_consumer_ff <= '0;
         in_doorbell_ff <= 1'b0;
         irq_allowed_ff <= 1'b0;
         irq_line_ff <= 1'b0;
      end else if (step) begin
         status_ff <= status_in;
         out_base_ff <= out_base_in;
         out_length_ff <= out_length_in;
         out_producer_ff <= out_producer_in;
         out_consumer_ff <= out_consumer_in;
         out_doorbell_ff <= out_doorbell_in;
         in_base_ff <= in_base_in;
         in_length_ff <= in_length_in;
         in_producer_ff <= in_producer_in;
         in_consumer_ff <= in_consumer_in;
         in_doorbell_ff <= in_doorbell_in;
         irq_allowed_ff <= irq_allowed_in;
         irq_line_ff <= irq_line_in;
      end
   end

   assign result.read_data = read_data;
   assign result.irq_level = irq_line_in;
   assign result.host_notify = notify;
   assign result.bad_access = bad;

endmodule

@@ hdl/dbmr_checker.sv @@
// ----------------------------------------------------------------------------
// dbmr_checker: port-level assertions for the doorbell mailbox registers
// Watches the response channel for results that cannot occur together and for stalled beats that change.
// ----------------------------------------------------------------------------
module dbmr_checker
   import dbmr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DataWidth-1:0] rsp_read_data,
   input logic                 rsp_host_notify,
   input logic                 rsp_bad_access
);

   // A rejected access never returns data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_access |-> rsp_read_data == '0)
      else $error("bad access beat carries read data");

   // A doorbell ring is a valid write and has no read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_host_notify |-> !rsp_bad_access && rsp_read_data == '0)
      else $error("host notify beat is not a clean doorbell write");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled response beat changed");

endmodule

bind doorbell_mailbox_registers dbmr_checker u_dbmr_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_host_notify (rsp_host_notify),
   .rsp_bad_access  (rsp_bad_access)
);
